>>> src/ccfp_pkg.sv
package ccfp_pkg;

  localparam int unsigned FRAME_LEN_DEF = 15;

  localparam logic [7:0] CHAR_START = 8'h4D;  // 'M'
  localparam logic [7:0] CHAR_END   = 8'h45;  // 'E'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int unsigned NUM_FIELDS  = 3;
  localparam int unsigned FIELD_CHARS = 3;
  localparam int unsigned FIELD_BASE  = 2;  // first char of first field
  localparam int unsigned FIELD_PITCH = 4;  // three chars and a comma

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_STOP = 2'd2,
    ACT_HALT = 2'd3
  } act_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       voltage_limit_reached;
  } rx_item_t;

  typedef struct packed {
    act_e       action;
    logic [8:0] current_request;
    logic [9:0] voltage_limit;
    logic       reverse_flow;
    logic       apply_current;
  } result_t;

  typedef logic [FIELD_CHARS-1:0][7:0] field_chars_t;

  // Closed frame handed from framer to decoder.
  typedef struct packed {
    logic [NUM_FIELDS-1:0][FIELD_CHARS-1:0][7:0] chars;
    logic                                         cv_reached;
  } frame_t;

  typedef logic signed [10:0] fval_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // atoi over a three character field: blanks, optional sign, digits.
  function automatic fval_t field_value(input field_chars_t ch);
    logic [1:0] phase;  // 0 skipping blanks, 1 in digits, 2 done
    logic       neg;
    logic [9:0] v;
    phase = 2'd0;
    neg   = 1'b0;
    v     = '0;
    for (int k = 0; k < FIELD_CHARS; k++) begin
      if (phase == 2'd0) begin
        if (is_blank(ch[k])) begin
          phase = 2'd0;
        end else if (ch[k] == CHAR_PLUS || ch[k] == CHAR_MINUS) begin
          neg   = (ch[k] == CHAR_MINUS);
          phase = 2'd1;
        end else if (is_digit(ch[k])) begin
          v     = {6'd0, ch[k][3:0]};
          phase = 2'd1;
        end else begin
          phase = 2'd2;
        end
      end else if (phase == 2'd1) begin
        if (is_digit(ch[k])) begin
          v = 10'(v * 10'd10 + {6'd0, ch[k][3:0]});
        end else begin
          phase = 2'd2;
        end
      end
    end
    return neg ? -fval_t'({1'b0, v}) : fval_t'({1'b0, v});
  endfunction

endpackage

>>> src/charger_command_frame_parser_unit.sv
// The 'E' pushes the frame into the frame queue; the decoder moves it on to the result queue.
// Throughput: one byte transaction per cycle while full is low; at most one result per FRAME_LEN bytes.
// full rises only while two closed frames wait on the decoder (result side stalled).
// The decoder is combinational and handles one frame per cycle while the result queue is not full.
// Reset (rst_ni low, async): frame position zero, forward direction, both queues empty.
module charger_command_frame_parser_unit #(
  parameter int unsigned FRAME_LEN = ccfp_pkg::FRAME_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ccfp_pkg::rx_item_t rx_item_i,
  output logic               empty,
  input  logic               pop,
  output ccfp_pkg::result_t  result_o
);
  import ccfp_pkg::*;

  // Front: framer counts bytes and latches the field characters.
  logic    accept;
  logic    frame_valid;
  frame_t  frame_in, frame_head;
  logic    frame_empty, frame_take;

  // Back: decoder turns a frame into one result transaction.
  logic    res_push, res_full;
  result_t res;

  assign accept = push && !full;

  ccfp_framer #(
    .FRAME_LEN(FRAME_LEN)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (rx_item_i),
    .frame_valid_o(frame_valid),
    .frame_o      (frame_in)
  );

  // Two-entry queue of closed frames between front and back; full here
  // is what stalls the byte input.
  ccfp_fifo #(
    .T(frame_t)
  ) u_frame_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (frame_valid),
    .data_i (frame_in),
    .full_o (full),
    .pop_i  (frame_take),
    .data_o (frame_head),
    .empty_o(frame_empty)
  );

  ccfp_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_avail_i(!frame_empty),
    .frame_i      (frame_head),
    .frame_take_o (frame_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // Result queue: keeps the decoder running while the consumer holds off pop.
  ccfp_fifo #(
    .T(result_t)
  ) u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

endmodule

>>> src/ccfp_fifo.sv
module ccfp_fifo #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  T           mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> src/ccfp_framer.sv
module ccfp_framer #(
  parameter int unsigned FRAME_LEN = ccfp_pkg::FRAME_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ccfp_pkg::rx_item_t item_i,
  output logic               frame_valid_o,
  output ccfp_pkg::frame_t   frame_o
);
  import ccfp_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_LEN);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LEN - 1);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic            closing;
  logic [NUM_FIELDS-1:0][FIELD_CHARS-1:0][7:0] chars_q;

  // 'M' restarts the frame and is itself counted as position zero.
  assign pos_eff = (item_i.rx_byte == CHAR_START) ? '0 : pos_q;
  assign closing = (pos_eff == LastPos);

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      pos_d = closing ? '0 : PosW'(pos_eff + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_q <= '0;
    else         pos_q <= pos_d;
  end

  // Only the field characters are kept; the rest are never read.
  always_ff @(posedge clk_i) begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      for (int k = 0; k < FIELD_CHARS; k++) begin
        if (accept_i && !closing &&
            pos_eff == PosW'(FIELD_BASE + FIELD_PITCH * f + k)) begin
          chars_q[f][k] <= item_i.rx_byte;
        end
      end
    end
  end

  assign frame_valid_o      = accept_i && closing && (item_i.rx_byte == CHAR_END);
  assign frame_o.chars      = chars_q;
  assign frame_o.cv_reached = item_i.voltage_limit_reached;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("frame position out of range");

  a_close_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && closing |=> pos_q == '0)
    else $error("frame did not restart after closing byte");

endmodule

>>> src/ccfp_decoder.sv
module ccfp_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_avail_i,
  input  ccfp_pkg::frame_t frame_i,
  output logic             frame_take_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output ccfp_pkg::result_t res_o
);
  import ccfp_pkg::*;

  logic              dir_q, dir_d;
  fval_t             cur_raw, volt_raw, chk_raw, cur, volt;
  logic signed [11:0] sum, sum_mod;
  logic              chk_ok, rev;
  result_t           res;

  assign cur_raw  = field_value(frame_i.chars[0]);
  assign volt_raw = field_value(frame_i.chars[1]);
  assign chk_raw  = field_value(frame_i.chars[2]);

  // Remainder truncates toward zero; |sum| stays below 2000.
  assign sum = 12'(cur_raw) + 12'(volt_raw);
  always_comb begin
    if (sum >= 12'sd1000)       sum_mod = sum - 12'sd1000;
    else if (sum <= -12'sd1000) sum_mod = sum + 12'sd1000;
    else                        sum_mod = sum;
  end
  assign chk_ok = (12'(chk_raw) == sum_mod);
  assign cur    = chk_ok ? cur_raw  : '0;
  assign volt   = chk_ok ? volt_raw : '0;
  assign rev    = (cur >= 11'sd500);

  always_comb begin
    dir_d                 = dir_q;
    res.action            = ACT_NONE;
    res.current_request   = '0;
    res.voltage_limit     = '0;
    res.apply_current     = 1'b0;
    if (cur > 11'sd1 && volt > 11'sd1) begin
      res.voltage_limit = volt[9:0];
      if (rev != dir_q) begin
        res.action = ACT_HALT;
      end else begin
        res.action          = ACT_RUN;
        res.current_request = rev ? 9'(cur - 11'sd500) : cur[8:0];
        res.apply_current   = !frame_i.cv_reached;
        dir_d               = rev;
      end
    end else if (cur == 11'sd1 && volt == 11'sd0) begin
      res.action = ACT_STOP;
    end
    res.reverse_flow = dir_d;
  end

  assign frame_take_o = frame_avail_i && !res_full_i;
  assign res_push_o   = frame_take_o;
  assign res_o        = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           dir_q <= 1'b0;
    else if (frame_take_o) dir_q <= dir_d;
  end

  a_halt_keeps_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res.action == ACT_HALT |=> dir_q == $past(dir_q))
    else $error("direction changed on halt");

  a_apply_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res.apply_current |-> res.action == ACT_RUN && !frame_i.cv_reached)
    else $error("current applied outside run");

endmodule
